@@ hw/rtl/smfb_pkg.sv @@
// Shared types, constants and helper functions of the softmax forward/backward block.
`timescale 1ns / 1ps
`default_nettype none
package smfb_pkg;

  localparam int MAX_LENGTH_DEF = 64;
  localparam int MAX_BATCH_DEF  = 16;

  localparam int ELEM_W     = 32;
  localparam int ROW_OUT_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int VLEN_W     = 7;
  localparam int BROWS_W    = 5;
  localparam int Q_W        = 25;   // Q0.24 value up to and including 1.0
  localparam int PROB_W     = 17;   // Q0.16 probability up to and including 1.0
  localparam int NUM_W      = 42;   // dividend q * 2^16 + sum / 2
  localparam int EXP_N_W    = 5;
  localparam int DPROD_W    = 50;

  localparam logic [Q_W-1:0]       Q_ONE      = Q_W'(25'h100_0000);
  localparam logic [EXP_N_W-1:0]   EXP_CUTOFF = EXP_N_W'(24);
  localparam logic [3:0]           TERMS      = 4'd9;

  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_ROWS    = CFG_IDX_W'(1);

  localparam logic CMD_FORWARD  = 1'b0;
  localparam logic CMD_BACKWARD = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic signed [ELEM_W-1:0] element;
  } item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] result_value;
    logic [ROW_OUT_W-1:0]     row_index;
    logic                     last;
  } result_t;

  // Row job handed from the front to the back
  typedef struct packed {
    logic valid;
    logic cmd;
  } job_t;

  typedef enum logic [4:0] {
    BK_IDLE, BK_E1_GO, BK_E1_WAIT, BK_MAX_RD, BK_MAX_ACC,
    BK_EXP_RD, BK_EXP_CALC, BK_EXP_GO, BK_EXP_WAIT, BK_EXP_ST,
    BK_DIV_RD, BK_DIV_GO, BK_DIV_WAIT, BK_EMIT_F,
    BK_DOT_RD, BK_DOT_MUL, BK_DOT_ACC,
    BK_BWD_RD, BK_BWD_DIFF, BK_BWD_ABS, BK_BWD_MUL, BK_BWD_EMIT
  } back_state_t;

  typedef enum logic [2:0] {
    EX_IDLE, EX_MUL, EX_RECIP, EX_UPD, EX_PMUL, EX_PUPD, EX_DONE
  } exp_state_t;

  typedef enum logic [1:0] {
    DV_IDLE, DV_RUN, DV_DONE
  } div_state_t;

  // ceil(2^32 / k): exact floor division by k for dividends below 2^29
  function automatic logic [31:0] recip_ceil(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655766;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993460;
      4'd6:    r = 32'd715827883;
      4'd7:    r = 32'd613566757;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218589;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/smfb_exp.sv @@
// Iterative exp(-a) unit: Horner series for the fraction, then repeated multiply by e^-1.
`timescale 1ns / 1ps
`default_nettype none
module smfb_exp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         go,
  input  wire logic [smfb_pkg::Q_W-1:0]     f24,
  input  wire logic [smfb_pkg::EXP_N_W-1:0] n,
  input  wire logic [smfb_pkg::Q_W-1:0]     e1,
  output logic                              done,
  output logic [smfb_pkg::Q_W-1:0]          q
);
  import smfb_pkg::*;

  localparam int P_W  = 2 * Q_W;
  localparam int P2_W = Q_W + 32;

  exp_state_t         state, state_next;
  logic [Q_W-1:0]     r;
  logic [Q_W-1:0]     f;
  logic [Q_W-1:0]     t;
  logic [3:0]         k;
  logic [EXP_N_W-1:0] cnt;
  logic [P_W-1:0]     p1;
  logic [P2_W-1:0]    p2;
  logic [P_W-1:0]     p1_rnd;

  assign p1_rnd = p1 + P_W'(Q_ONE >> 1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      EX_IDLE:  if (go) state_next = EX_MUL;
      EX_MUL:   state_next = EX_RECIP;
      EX_RECIP: state_next = EX_UPD;
      EX_UPD: begin
        if (k != 4'd1) state_next = EX_MUL;
        else if (cnt == '0) state_next = EX_DONE;
        else state_next = EX_PMUL;
      end
      EX_PMUL:  state_next = EX_PUPD;
      EX_PUPD:  state_next = (cnt == EXP_N_W'(1)) ? EX_DONE : EX_PMUL;
      EX_DONE:  state_next = EX_IDLE;
      default:  state_next = EX_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = (state == EX_DONE);
    q    = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: one multiply per cycle, registered before the next
  always_ff @(posedge clk) begin
    case (state)
      EX_IDLE: begin
        if (go) begin
          r   <= Q_ONE;
          f   <= f24;
          k   <= TERMS;
          cnt <= n;
        end
      end
      EX_MUL:   p1 <= P_W'(f) * P_W'(r);
      EX_RECIP: begin
        t  <= p1[2*Q_W-2:Q_W-1];
        p2 <= P2_W'(p1[2*Q_W-2:Q_W-1]) * P2_W'(recip_ceil(k));
      end
      EX_UPD: begin
        r <= Q_ONE - ((k == 4'd1) ? t : p2[P2_W-1:32]);
        k <= k - 4'd1;
      end
      EX_PMUL:  p1 <= P_W'(r) * P_W'(e1);
      EX_PUPD: begin
        r   <= p1_rnd[2*Q_W-2:Q_W-1];
        cnt <= cnt - EXP_N_W'(1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/smfb_div.sv @@
// Restoring divider, one quotient bit a cycle, for the probability normalisation.
`timescale 1ns / 1ps
`default_nettype none
module smfb_div #(
  parameter int SUM_W = 31
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        go,
  input  wire logic [smfb_pkg::NUM_W-1:0]  num,
  input  wire logic [SUM_W-1:0]            den,
  output logic                             done,
  output logic [smfb_pkg::PROB_W-1:0]      quo
);
  import smfb_pkg::*;

  localparam int CNT_W = $clog2(PROB_W + 1);

  div_state_t        state, state_next;
  logic [SUM_W-1:0]  rem;
  logic [PROB_W-1:0] lowb;
  logic [PROB_W-1:0] qbits;
  logic [CNT_W-1:0]  cnt;
  logic [SUM_W:0]    rem2;
  logic              fits;

  assign rem2 = {rem, lowb[PROB_W-1]};
  assign fits = (rem2 >= {1'b0, den});

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE: if (go) state_next = DV_RUN;
      DV_RUN:  if (cnt == CNT_W'(1)) state_next = DV_DONE;
      DV_DONE: state_next = DV_IDLE;
      default: state_next = DV_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = (state == DV_DONE);
    quo  = qbits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Upper dividend bits start below the divisor, so only the low bits make quotient
  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (go) begin
          rem  <= SUM_W'(num[NUM_W-1:PROB_W]);
          lowb <= num[PROB_W-1:0];
          cnt  <= CNT_W'(PROB_W);
        end
      end
      DV_RUN: begin
        rem   <= fits ? SUM_W'(rem2 - {1'b0, den}) : SUM_W'(rem2);
        qbits <= {qbits[PROB_W-2:0], fits};
        lowb  <= {lowb[PROB_W-2:0], 1'b0};
        cnt   <= cnt - CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/smfb_front.sv @@
// Front end: buffers incoming words into the row buffer and queues completed row jobs.
`timescale 1ns / 1ps
`default_nettype none
module smfb_front #(
  parameter int MAX_LENGTH = smfb_pkg::MAX_LENGTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire smfb_pkg::item_t                   item,
  input  wire logic [$clog2(MAX_LENGTH+1)-1:0]   eff_len,
  input  wire logic                              pop,
  output smfb_pkg::job_t                         job,
  input  wire logic [$clog2(MAX_LENGTH)-1:0]     rb_raddr,
  output logic [smfb_pkg::ELEM_W-1:0]            rb_rdata
);
  import smfb_pkg::*;

  localparam int IDX_W = $clog2(MAX_LENGTH);
  localparam int CNT_W = $clog2(MAX_LENGTH + 1);

  logic [ELEM_W-1:0] row_buffer [MAX_LENGTH];
  logic [IDX_W-1:0]  count;
  logic [CNT_W-1:0]  count_inc;
  logic              complete;
  logic              push;
  logic              q_cmd [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        q_count;

  assign count_inc = CNT_W'(count) + CNT_W'(1);
  assign complete  = (count_inc >= eff_len);
  assign push      = accept && complete;

  // Row buffer: write on accept, registered read for the back end
  always_ff @(posedge clk) begin
    if (accept) begin
      row_buffer[count] <= item.element;
    end
    rb_rdata <= row_buffer[rb_raddr];
  end

  // Advance the element count, drop it to zero when a row completes
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= complete ? '0 : count_inc[IDX_W-1:0];
    end
  end

  // Two-entry job queue
  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd[wr_ptr] <= item.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

  assign job.valid = (q_count != 2'd0);
  assign job.cmd   = q_cmd[rd_ptr];

endmodule
`default_nettype wire

@@ hw/rtl/smfb_back.sv @@
// Back end: sequences the forward and backward passes over a buffered row and emits results.
`timescale 1ns / 1ps
`default_nettype none
module smfb_back #(
  parameter int MAX_LENGTH = smfb_pkg::MAX_LENGTH_DEF,
  parameter int MAX_BATCH  = smfb_pkg::MAX_BATCH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire smfb_pkg::job_t                    job,
  output logic                                   pop,
  output logic                                   active,
  input  wire logic [$clog2(MAX_LENGTH+1)-1:0]   eff_len,
  input  wire logic [$clog2(MAX_BATCH+1)-1:0]    eff_batch,
  output logic [$clog2(MAX_LENGTH)-1:0]          rb_raddr,
  input  wire logic [smfb_pkg::ELEM_W-1:0]       rb_rdata,
  output smfb_pkg::result_t                      result,
  output logic                                   result_valid
);
  import smfb_pkg::*;

  localparam int IDX_W    = $clog2(MAX_LENGTH);
  localparam int CNT_W    = $clog2(MAX_LENGTH + 1);
  localparam int ROW_W    = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int BAT_W    = $clog2(MAX_BATCH + 1);
  localparam int RC_W     = (ROW_W + 1 > BAT_W) ? ROW_W + 1 : BAT_W;
  localparam int PS_DEPTH = MAX_BATCH * MAX_LENGTH;
  localparam int PS_AW    = $clog2(PS_DEPTH);
  localparam int SUM_W    = Q_W + IDX_W;
  localparam int DOT_W    = DPROD_W + IDX_W;
  localparam int DIFF_W   = DOT_W + 1;
  localparam int HI_W     = DIFF_W - 32;
  localparam int HP_W     = HI_W + PROB_W;
  localparam int LP_W     = 32 + PROB_W;
  localparam int M_W      = HP_W + 1;
  localparam int A_W      = ELEM_W + 1;

  back_state_t               state, state_next;
  logic [CNT_W-1:0]          idx;
  logic [IDX_W-1:0]          idx_i;
  logic                      is_last;
  logic [ROW_W-1:0]          fwd_row;
  logic [ROW_W-1:0]          bwd_row;
  logic [ROW_W-1:0]          cur_row;
  logic [RC_W-1:0]           row_inc;
  logic [ROW_W-1:0]          row_adv;
  logic signed [ELEM_W-1:0]  mx;
  logic [A_W-1:0]            a_r;
  logic                      a_big;
  logic [Q_W-1:0]            e1;
  logic [Q_W-1:0]            cur_q;
  logic [SUM_W-1:0]          sum;
  logic [PROB_W-1:0]         pr;
  logic signed [DPROD_W-1:0] dprod;
  logic signed [DOT_W-1:0]   dot;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         mag;
  logic                      neg;
  logic [HP_W-1:0]           hi_prod;
  logic [LP_W-1:0]           lo_prod;
  logic [LP_W:0]             lo_rnd;
  logic [M_W-1:0]            m;
  logic [ELEM_W-1:0]         bwd_val;

  logic [Q_W-1:0]            qbuf [MAX_LENGTH];
  logic [Q_W-1:0]            q_rdata;
  logic [PROB_W-1:0]         prob_store [PS_DEPTH];
  logic [PROB_W-1:0]         ps_rdata;
  logic [PS_AW-1:0]          ps_addr;
  logic                      ps_we;

  logic                      exp_go;
  logic [Q_W-1:0]            exp_f24;
  logic [EXP_N_W-1:0]        exp_n;
  logic                      exp_done;
  logic [Q_W-1:0]            exp_q;
  logic                      div_go;
  logic [NUM_W-1:0]          div_num;
  logic                      div_done;
  logic [PROB_W-1:0]         div_quo;

  assign idx_i   = idx[IDX_W-1:0];
  assign is_last = (idx == eff_len - CNT_W'(1));
  assign ps_addr = PS_AW'(cur_row) * PS_AW'(MAX_LENGTH) + PS_AW'(idx_i);
  assign row_inc = RC_W'(cur_row) + RC_W'(1);
  assign row_adv = (row_inc >= RC_W'(eff_batch)) ? '0 : ROW_W'(row_inc);
  assign a_big   = (a_r[A_W-1:16] >= (A_W-16)'(EXP_CUTOFF));
  assign div_num = NUM_W'({q_rdata, 16'd0}) + NUM_W'(sum >> 1);
  assign lo_rnd  = (LP_W+1)'(lo_prod) + (LP_W+1)'(33'h0_8000_0000);
  assign m       = M_W'(hi_prod) + M_W'(lo_rnd[LP_W:32]);

  // Round half away from zero has been applied to the magnitude; saturate to 32 bits
  always_comb begin
    if (neg) begin
      if (m > M_W'(33'h1_0000_0000 >> 1)) bwd_val = 32'h8000_0000;
      else bwd_val = 32'(M_W'(0) - m);
    end else begin
      if (m > M_W'(32'h7FFF_FFFF)) bwd_val = 32'h7FFF_FFFF;
      else bwd_val = 32'(m);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (job.valid) state_next = (job.cmd == CMD_BACKWARD) ? BK_DOT_RD : BK_E1_GO;
      end
      BK_E1_GO:    state_next = BK_E1_WAIT;
      BK_E1_WAIT:  if (exp_done) state_next = BK_MAX_RD;
      BK_MAX_RD:   state_next = BK_MAX_ACC;
      BK_MAX_ACC:  state_next = is_last ? BK_EXP_RD : BK_MAX_RD;
      BK_EXP_RD:   state_next = BK_EXP_CALC;
      BK_EXP_CALC: state_next = BK_EXP_GO;
      BK_EXP_GO:   state_next = a_big ? BK_EXP_ST : BK_EXP_WAIT;
      BK_EXP_WAIT: if (exp_done) state_next = BK_EXP_ST;
      BK_EXP_ST:   state_next = is_last ? BK_DIV_RD : BK_EXP_RD;
      BK_DIV_RD:   state_next = BK_DIV_GO;
      BK_DIV_GO:   state_next = BK_DIV_WAIT;
      BK_DIV_WAIT: if (div_done) state_next = BK_EMIT_F;
      BK_EMIT_F:   state_next = is_last ? BK_IDLE : BK_DIV_RD;
      BK_DOT_RD:   state_next = BK_DOT_MUL;
      BK_DOT_MUL:  state_next = BK_DOT_ACC;
      BK_DOT_ACC:  state_next = is_last ? BK_BWD_RD : BK_DOT_RD;
      BK_BWD_RD:   state_next = BK_BWD_DIFF;
      BK_BWD_DIFF: state_next = BK_BWD_ABS;
      BK_BWD_ABS:  state_next = BK_BWD_MUL;
      BK_BWD_MUL:  state_next = BK_BWD_EMIT;
      BK_BWD_EMIT: state_next = is_last ? BK_IDLE : BK_BWD_RD;
      default:     state_next = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop      = (state == BK_IDLE) && job.valid;
    active   = (state != BK_IDLE);
    rb_raddr = idx_i;
    exp_go   = (state == BK_E1_GO) || ((state == BK_EXP_GO) && !a_big);
    exp_f24  = (state == BK_E1_GO) ? Q_ONE : {1'b0, a_r[15:0], 8'd0};
    exp_n    = (state == BK_E1_GO) ? '0 : a_r[20:16];
    div_go   = (state == BK_DIV_GO);
    ps_we    = (state == BK_EMIT_F);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Exponent and probability memories
  always_ff @(posedge clk) begin
    if (state == BK_EXP_ST) begin
      qbuf[idx_i] <= cur_q;
    end
    q_rdata <= qbuf[idx_i];
  end

  always_ff @(posedge clk) begin
    if (ps_we) begin
      prob_store[ps_addr] <= pr;
    end
    ps_rdata <= prob_store[ps_addr];
  end

  // Row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_row <= '0;
      bwd_row <= '0;
    end else begin
      if ((state == BK_EMIT_F) && is_last) fwd_row <= row_adv;
      if ((state == BK_BWD_EMIT) && is_last) bwd_row <= row_adv;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == BK_EMIT_F) || (state == BK_BWD_EMIT);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        idx     <= '0;
        dot     <= '0;
        sum     <= '0;
        cur_row <= (job.cmd == CMD_BACKWARD) ? bwd_row : fwd_row;
      end
      BK_E1_WAIT: if (exp_done) e1 <= exp_q;
      BK_MAX_ACC: begin
        if ((idx == '0) || ($signed(rb_rdata) > mx)) mx <= $signed(rb_rdata);
        idx <= is_last ? '0 : idx + CNT_W'(1);
      end
      BK_EXP_CALC: a_r <= A_W'(A_W'(mx) - A_W'($signed(rb_rdata)));
      BK_EXP_GO:   if (a_big) cur_q <= '0;
      BK_EXP_WAIT: if (exp_done) cur_q <= exp_q;
      BK_EXP_ST: begin
        sum <= sum + SUM_W'(cur_q);
        idx <= is_last ? '0 : idx + CNT_W'(1);
      end
      BK_DIV_WAIT: if (div_done) pr <= div_quo;
      BK_EMIT_F: begin
        result.result_value <= $signed(ELEM_W'(pr));
        result.row_index    <= ROW_OUT_W'(cur_row);
        result.last         <= is_last;
        idx                 <= idx + CNT_W'(1);
      end
      BK_DOT_MUL: dprod <= $signed(rb_rdata) * $signed({1'b0, ps_rdata});
      BK_DOT_ACC: begin
        dot <= dot + DOT_W'(dprod);
        idx <= is_last ? '0 : idx + CNT_W'(1);
      end
      BK_BWD_DIFF: begin
        diff <= (DIFF_W'($signed(rb_rdata)) <<< 16) - DIFF_W'(dot);
        pr   <= ps_rdata;
      end
      BK_BWD_ABS: begin
        neg <= diff[DIFF_W-1];
        mag <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      end
      BK_BWD_MUL: begin
        hi_prod <= HP_W'(mag[DIFF_W-1:32]) * HP_W'(pr);
        lo_prod <= LP_W'(mag[31:0]) * LP_W'(pr);
      end
      BK_BWD_EMIT: begin
        result.result_value <= $signed(bwd_val);
        result.row_index    <= ROW_OUT_W'(cur_row);
        result.last         <= is_last;
        idx                 <= idx + CNT_W'(1);
      end
      default: ;
    endcase
  end

  smfb_exp u_exp (
    .clk  (clk),
    .rst  (rst),
    .go   (exp_go),
    .f24  (exp_f24),
    .n    (exp_n),
    .e1   (e1),
    .done (exp_done),
    .q    (exp_q)
  );

  smfb_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (sum),
    .done (div_done),
    .quo  (div_quo)
  );

endmodule
`default_nettype wire

@@ hw/rtl/softmax_forward_backward.sv @@
// Top level of the softmax forward/backward block: config registers, front, back.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+------------------------------
//  input    | start, busy, item{cmd, element}           | taken when start & !busy
//  result   | result_valid, result{value, row, last}    | one-cycle strobe, no stall
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | taken when cfg_valid & cfg_ready
//
// An element that does not complete a row is taken and busy stays low.
// A completed row keeps busy high while the back end runs it. The forward pass
// runs on the iterative exp unit and the bit-serial divider; an element with
// n_i of 24 or more (n_i = integer part of max - x_i) skips the exp unit.
// Reset is synchronous and clears counters and control.
// Results cannot be stalled; each appears for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module softmax_forward_backward #(
  parameter int MAX_LENGTH = smfb_pkg::MAX_LENGTH_DEF,
  parameter int MAX_BATCH  = smfb_pkg::MAX_BATCH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire smfb_pkg::item_t                   item,
  output smfb_pkg::result_t                      result,
  output logic                                   result_valid,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [smfb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [smfb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import smfb_pkg::*;

  localparam int IDX_W = $clog2(MAX_LENGTH);
  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam int BAT_W = $clog2(MAX_BATCH + 1);

  logic [VLEN_W-1:0]  vector_length;
  logic [BROWS_W-1:0] batch_rows;
  logic [CNT_W-1:0]   eff_len;
  logic [BAT_W-1:0]   eff_batch;
  logic               accept;
  logic               pop;
  logic               back_active;
  job_t               job;
  logic [IDX_W-1:0]   rb_raddr;
  logic [ELEM_W-1:0]  rb_rdata;

  assign cfg_ready = 1'b1;
  assign busy      = job.valid || back_active;
  assign accept    = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= VLEN_W'(64);
      batch_rows    <= BROWS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VECTOR_LENGTH: vector_length <= cfg_data[VLEN_W-1:0];
        REG_BATCH_ROWS:    batch_rows    <= cfg_data[BROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to the supported range
  always_comb begin
    if (vector_length == '0) eff_len = CNT_W'(1);
    else if (32'(vector_length) > 32'(MAX_LENGTH)) eff_len = CNT_W'(MAX_LENGTH);
    else eff_len = CNT_W'(vector_length);
    if (batch_rows == '0) eff_batch = BAT_W'(1);
    else if (32'(batch_rows) > 32'(MAX_BATCH)) eff_batch = BAT_W'(MAX_BATCH);
    else eff_batch = BAT_W'(batch_rows);
  end

  smfb_front #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .eff_len  (eff_len),
    .pop      (pop),
    .job      (job),
    .rb_raddr (rb_raddr),
    .rb_rdata (rb_rdata)
  );

  smfb_back #(
    .MAX_LENGTH (MAX_LENGTH),
    .MAX_BATCH  (MAX_BATCH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job          (job),
    .pop          (pop),
    .active       (back_active),
    .eff_len      (eff_len),
    .eff_batch    (eff_batch),
    .rb_raddr     (rb_raddr),
    .rb_rdata     (rb_rdata),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
`default_nettype wire

@@ hw/rtl/smfb_checker.sv @@
// Port-level checks of the softmax forward/backward block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module smfb_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              result_valid,
  input wire smfb_pkg::result_t result
);

  // No result the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result strobe after reset");

  // A row still being emitted keeps the block busy
  a_busy_mid_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("busy low in the middle of a row");

  // The final word of a row is never followed at once by another word
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("result straight after the last word of a row");

  // Busy rises only after a word was taken
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

endmodule

bind softmax_forward_backward smfb_checker u_smfb_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
`default_nettype wire
